// ===== hw/rtl/fms_pkg.sv =====
// Package: shared widths, configuration register indexes and scaling constants.
`default_nettype none

package fms_pkg;

  // Configuration channel geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALT_TOL     = 3'd0,
    CFG_YAW_TOL     = 3'd1,
    CFG_ALT_STEP    = 3'd2,
    CFG_YAW_STEP    = 3'd3,
    CFG_START_DELAY = 3'd4,
    CFG_ALT_CEIL    = 3'd5,
    CFG_HOVER_YAW   = 3'd6
  } cfg_idx_e;

  // Flight mode codes on the result channel
  typedef enum logic [2:0] {
    FM_LANDED  = 3'd0,
    FM_TAKEOFF = 3'd1,
    FM_HOVER   = 3'd2,
    FM_FLYING  = 3'd3,
    FM_LANDING = 3'd4
  } flight_mode_e;

  // x*100/1241 as x*PCT_RECIP >> PCT_SHIFT, exact for 16-bit magnitudes
  localparam int PCT_SHIFT = 35;
  localparam logic [31:0] PCT_RECIP =
    32'(((64'd100 << PCT_SHIFT) + 64'd1240) / 64'd1241);

  // x*1241/100 as x*CNT_RECIP >> CNT_SHIFT, exact for 7-bit targets
  localparam int CNT_SHIFT = 16;
  localparam logic [19:0] CNT_RECIP =
    20'(((64'd1241 << CNT_SHIFT) + 64'd99) / 64'd100);

  // x*112/90 as x*STEP_RECIP >> STEP_SHIFT, exact for 9-bit magnitudes
  localparam int STEP_SHIFT = 16;
  localparam logic [16:0] STEP_RECIP =
    17'(((64'd56 << STEP_SHIFT) + 64'd44) / 64'd45);

endpackage

`default_nettype wire

// ===== hw/rtl/fms_if.sv =====
// Interfaces: configuration write, tick input and result channels.
`default_nettype none

interface fms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fms_pkg::CFG_IDX_W-1:0]  index;
  logic [fms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface fms_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] height_sample;
  logic signed [8:0]      measured_yaw;
  logic                   switch_up;
  logic                   push_up;
  logic                   push_down;
  logic                   push_left;
  logic                   push_right;
  logic                   reference_found;

  modport source (output valid, output height_sample, output measured_yaw,
                  output switch_up, output push_up, output push_down,
                  output push_left, output push_right, output reference_found,
                  input ready);
  modport sink   (input valid, input height_sample, input measured_yaw,
                  input switch_up, input push_up, input push_down,
                  input push_left, input push_right, input reference_found,
                  output ready);
endinterface

interface fms_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        flight_mode;
  logic signed [9:0] altitude_pct;
  logic [6:0]        altitude_target;
  logic signed [8:0] yaw_target;
  logic [10:0]       altitude_target_counts;
  logic signed [8:0] yaw_target_steps;
  logic              main_motor_on;
  logic              tail_motor_on;
  logic              altitude_target_load;
  logic              yaw_target_load;
  logic              clear_main_integrator;
  logic              clear_tail_integrator;

  modport source (output valid, output flight_mode, output altitude_pct,
                  output altitude_target, output yaw_target,
                  output altitude_target_counts, output yaw_target_steps,
                  output main_motor_on, output tail_motor_on,
                  output altitude_target_load, output yaw_target_load,
                  output clear_main_integrator, output clear_tail_integrator,
                  input ready);
  modport sink   (input valid, input flight_mode, input altitude_pct,
                  input altitude_target, input yaw_target,
                  input altitude_target_counts, input yaw_target_steps,
                  input main_motor_on, input tail_motor_on,
                  input altitude_target_load, input yaw_target_load,
                  input clear_main_integrator, input clear_tail_integrator,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fms_pct_conv.sv =====
// Height sample to altitude percent against the ground reference, saturated.
`default_nettype none

module fms_pct_conv #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0] ground_ref_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic signed [9:0]      pct_o
);

  localparam int PW = SAMPLE_BITS + $bits(fms_pkg::PCT_RECIP);
  localparam int QW = PW - fms_pkg::PCT_SHIFT;
  localparam int XW = (QW > 10) ? QW : 10;

  logic [SAMPLE_BITS:0]   diff;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          quo;
  logic [XW-1:0]          quo_x;

  // Magnitude of the exact difference, then truncating scale
  assign diff  = {1'b0, ground_ref_i} - {1'b0, sample_i};
  assign neg   = diff[SAMPLE_BITS];
  assign mag   = neg ? SAMPLE_BITS'({1'b0, sample_i} - {1'b0, ground_ref_i})
                     : diff[SAMPLE_BITS-1:0];
  assign prod  = PW'(mag) * PW'(fms_pkg::PCT_RECIP);
  assign quo   = prod[PW-1:fms_pkg::PCT_SHIFT];
  assign quo_x = XW'(quo);

  // Saturate to the 10-bit signed range
  always_comb begin
    if (neg) begin
      if (quo_x >= XW'(512)) pct_o = -10'sd512;
      else                   pct_o = $signed(10'(10'd0 - quo_x[9:0]));
    end else begin
      if (quo_x > XW'(511))  pct_o = 10'sd511;
      else                   pct_o = $signed(quo_x[9:0]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fms_target_conv.sv =====
// Targets to controller units: ADC counts and encoder steps.
`default_nettype none

module fms_target_conv (
  input  logic [6:0]        alt_target_i,
  input  logic signed [8:0] yaw_target_i,
  output logic [10:0]       counts_o,
  output logic signed [8:0] steps_o
);

  localparam int CPW = 7 + $bits(fms_pkg::CNT_RECIP);
  localparam int SPW = 9 + $bits(fms_pkg::STEP_RECIP);

  logic [CPW-1:0] cnt_prod;
  logic           yaw_neg;
  logic [8:0]     yaw_mag;
  logic [SPW-1:0] step_prod;
  logic [SPW-1-fms_pkg::STEP_SHIFT:0] step_quo;

  // Percent to counts, truncated
  assign cnt_prod = CPW'(alt_target_i) * CPW'(fms_pkg::CNT_RECIP);
  assign counts_o = cnt_prod[fms_pkg::CNT_SHIFT +: 11];

  // Degrees to steps, truncated toward zero
  assign yaw_neg   = yaw_target_i[8];
  assign yaw_mag   = yaw_neg ? 9'(9'd0 - $unsigned(yaw_target_i)) : $unsigned(yaw_target_i);
  assign step_prod = SPW'(yaw_mag) * SPW'(fms_pkg::STEP_RECIP);
  assign step_quo  = step_prod[SPW-1:fms_pkg::STEP_SHIFT];

  always_comb begin
    if (yaw_neg) begin
      if (step_quo >= 10'd256) steps_o = -9'sd256;
      else                     steps_o = $signed(9'(9'd0 - step_quo[8:0]));
    end else begin
      if (step_quo > 10'd255)  steps_o = 9'sd255;
      else                     steps_o = $signed(step_quo[8:0]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flight_mode_setpoint_sequencer.sv =====
// Top level: flight mode sequencer with target stepping and unit scaling.
//
//  channel  modport  direction  carries
//  cfg_i    sink     in         register index and write data, always ready
//  in_i     sink     in         one control tick: height, yaw, switch, buttons
//  out_o    source   out        mode, targets, motor levels, command pulses
//
// One tick per clock sustained while results are taken; a tick is captured in the
// input register, then moves on to the result register. Altitude percent is formed
// while the tick is captured, against a forwarded ground reference.
// A stalled result holds one more tick in the input register; in_i.ready drops
// only when both registers are full. Asynchronous reset clears the mode state
// and loads the register defaults; no memory needs a clearing pass.
`default_nettype none

module flight_mode_setpoint_sequencer #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fms_cfg_if.sink   cfg_i,
  fms_in_if.sink    in_i,
  fms_out_if.source out_o
);

  typedef enum logic [4:0] {
    MODE_LANDED  = 5'b00001,
    MODE_TAKEOFF = 5'b00010,
    MODE_HOVER   = 5'b00100,
    MODE_FLYING  = 5'b01000,
    MODE_LANDING = 5'b10000
  } mode_e;

  // Configuration registers
  logic [4:0]        atol_q, ytol_q, delay_q;
  logic [5:0]        astep_q, ystep_q;
  logic [6:0]        ceil_q;
  logic signed [8:0] hover_yaw_q;

  // Sequencer state
  mode_e                  mode_q, mode_d;
  logic [6:0]             alt_goal_q, alt_goal_d;
  logic signed [8:0]      yaw_goal_q, yaw_goal_d;
  logic [4:0]             start_cnt_q, start_cnt_d;
  logic                   start_done_q, start_done_d;
  logic [SAMPLE_BITS-1:0] gref_q, gref_d, gref_fwd;
  logic                   main_on_q, main_on_d;
  logic                   tail_on_q, tail_on_d;

  // Input register
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic signed [9:0]      s1_pct_q;
  logic signed [8:0]      s1_myaw_q;
  logic                   s1_sw_q, s1_up_q, s1_down_q, s1_left_q, s1_right_q, s1_found_q;

  // Result register
  logic              out_valid_q;
  logic [2:0]        out_mode_q;
  logic signed [9:0] out_pct_q;
  logic [6:0]        out_alt_q;
  logic signed [8:0] out_yaw_q;
  logic [10:0]       out_counts_q;
  logic signed [8:0] out_steps_q;
  logic              out_main_q, out_tail_q, out_aload_q, out_yload_q;
  logic              out_cmain_q, out_ctail_q;

  // Working signals
  logic              in_fire, advance;
  logic signed [9:0] in_pct;
  logic [8:0]        myaw_mag;
  logic              yaw_ok;
  logic signed [10:0] pct_w, to_diff;
  logic [10:0]       to_err;
  logic [9:0]        lim1, lim2;
  logic              near1, near2;
  logic [6:0]        land_goal;
  logic [7:0]        up_sum;
  logic signed [10:0] ystep_s, yaw_w;
  logic              aload, yload, cmain, ctail;
  logic [2:0]        mode_code;
  logic [10:0]       counts;
  logic signed [8:0] steps;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atol_q      <= 5'd4;
      ytol_q      <= 5'd5;
      astep_q     <= 6'd10;
      ystep_q     <= 6'd15;
      delay_q     <= 5'd10;
      ceil_q      <= 7'd100;
      hover_yaw_q <= -9'sd30;
    end else if (cfg_i.valid) begin
      case (fms_pkg::cfg_idx_e'(cfg_i.index))
        fms_pkg::CFG_ALT_TOL:     atol_q      <= cfg_i.data[4:0];
        fms_pkg::CFG_YAW_TOL:     ytol_q      <= cfg_i.data[4:0];
        fms_pkg::CFG_ALT_STEP:    astep_q     <= cfg_i.data[5:0];
        fms_pkg::CFG_YAW_STEP:    ystep_q     <= cfg_i.data[5:0];
        fms_pkg::CFG_START_DELAY: delay_q     <= cfg_i.data[4:0];
        fms_pkg::CFG_ALT_CEIL:    ceil_q      <= cfg_i.data[6:0];
        fms_pkg::CFG_HOVER_YAW:   hover_yaw_q <= $signed(cfg_i.data[8:0]);
        default: ;
      endcase
    end
  end

  // Handshake: input register frees when its tick moves to the result register
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // Percent uses the reference as it stands after the tick ahead updates it
  assign gref_fwd = advance ? gref_d : gref_q;

  fms_pct_conv #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pct (
    .ground_ref_i (gref_fwd),
    .sample_i     (in_i.height_sample),
    .pct_o        (in_pct)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= in_i.height_sample;
      s1_pct_q    <= in_pct;
      s1_myaw_q   <= in_i.measured_yaw;
      s1_sw_q     <= in_i.switch_up;
      s1_up_q     <= in_i.push_up;
      s1_down_q   <= in_i.push_down;
      s1_left_q   <= in_i.push_left;
      s1_right_q  <= in_i.push_right;
      s1_found_q  <= in_i.reference_found;
    end
  end

  // Shared comparisons for take-off and landing
  assign myaw_mag = s1_myaw_q[8] ? 9'(9'd0 - $unsigned(s1_myaw_q)) : $unsigned(s1_myaw_q);
  assign yaw_ok   = myaw_mag <= {4'd0, ytol_q};
  assign pct_w    = 11'(s1_pct_q);
  assign to_diff  = pct_w - $signed({4'd0, alt_goal_q});
  assign to_err   = to_diff[10] ? 11'(11'd0 - $unsigned(to_diff)) : $unsigned(to_diff);

  assign lim1  = {3'd0, alt_goal_q} + {5'd0, atol_q};
  assign near1 = yaw_ok && (pct_w <= $signed({1'b0, lim1}));
  always_comb begin
    land_goal = alt_goal_q;
    if (near1 && (alt_goal_q != 7'd0)) begin
      land_goal = (alt_goal_q >= {1'b0, astep_q}) ? (alt_goal_q - {1'b0, astep_q}) : 7'd0;
    end
  end
  assign lim2  = {3'd0, land_goal} + {5'd0, atol_q};
  assign near2 = yaw_ok && (pct_w <= $signed({1'b0, lim2}));

  assign ystep_s = $signed({5'd0, ystep_q});

  // Mode sequencer
  always_comb begin
    mode_d       = mode_q;
    alt_goal_d   = alt_goal_q;
    yaw_goal_d   = yaw_goal_q;
    start_cnt_d  = start_cnt_q;
    start_done_d = start_done_q;
    gref_d       = gref_q;
    main_on_d    = main_on_q;
    tail_on_d    = tail_on_q;
    aload        = 1'b0;
    yload        = 1'b0;
    cmain        = 1'b0;
    ctail        = 1'b0;
    up_sum       = 8'd0;
    yaw_w        = 11'(yaw_goal_q);
    case (mode_q)
      MODE_TAKEOFF: begin
        if (start_done_q && (to_err <= {6'd0, atol_q})) begin
          mode_d     = MODE_HOVER;
          yaw_goal_d = hover_yaw_q;
          yload      = 1'b1;
        end
        if (!start_done_q) begin
          if (start_cnt_q >= delay_q) begin
            cmain        = 1'b1;
            main_on_d    = 1'b1;
            alt_goal_d   = ({1'b0, astep_q} > ceil_q) ? ceil_q : {1'b0, astep_q};
            aload        = 1'b1;
            start_done_d = 1'b1;
          end else begin
            start_cnt_d = start_cnt_q + 5'd1;
          end
        end
      end
      MODE_HOVER: begin
        ctail = 1'b1;
        if (s1_found_q) begin
          yload      = 1'b1;
          yaw_goal_d = 9'sd0;
          mode_d     = MODE_FLYING;
        end
      end
      MODE_FLYING: begin
        // Altitude buttons: up first, then down
        if (s1_up_q) begin
          up_sum     = {1'b0, alt_goal_d} + {2'd0, astep_q};
          alt_goal_d = (up_sum > {1'b0, ceil_q}) ? ceil_q : up_sum[6:0];
          aload      = 1'b1;
        end
        if (s1_down_q) begin
          alt_goal_d = (alt_goal_d >= {1'b0, astep_q}) ? (alt_goal_d - {1'b0, astep_q})
                                                       : 7'd0;
          aload      = 1'b1;
        end
        // Yaw buttons with wrap: right first, then left
        if (s1_right_q) begin
          if (yaw_w >= 11'sd180) yaw_w = -11'sd180;
          yaw_w = yaw_w + ystep_s;
          yload = 1'b1;
        end
        if (s1_left_q) begin
          if (yaw_w <= (-11'sd180 + ystep_s)) yaw_w = 11'sd180 + ystep_s;
          yaw_w = yaw_w - ystep_s;
          yload = 1'b1;
        end
        yaw_goal_d = 9'(yaw_w);
        if (!s1_sw_q) begin
          mode_d     = MODE_LANDING;
          yaw_goal_d = 9'sd0;
          yload      = 1'b1;
        end
      end
      MODE_LANDING: begin
        if (near1 && (alt_goal_q != 7'd0)) begin
          aload = 1'b1;
        end
        alt_goal_d = land_goal;
        if (near2 && (land_goal == 7'd0)) begin
          mode_d    = MODE_LANDED;
          main_on_d = 1'b0;
          tail_on_d = 1'b0;
        end
      end
      default: begin
        // Landed: recapture the ground reference every tick
        mode_d = MODE_LANDED;
        gref_d = s1_sample_q;
        if (s1_sw_q) begin
          tail_on_d    = 1'b1;
          yaw_goal_d   = 9'sd0;
          start_cnt_d  = 5'd0;
          start_done_d = 1'b0;
          yload        = 1'b1;
          cmain        = 1'b1;
          mode_d       = MODE_TAKEOFF;
        end
      end
    endcase
  end

  always_comb begin
    case (mode_d)
      MODE_TAKEOFF: mode_code = fms_pkg::FM_TAKEOFF;
      MODE_HOVER:   mode_code = fms_pkg::FM_HOVER;
      MODE_FLYING:  mode_code = fms_pkg::FM_FLYING;
      MODE_LANDING: mode_code = fms_pkg::FM_LANDING;
      default:      mode_code = fms_pkg::FM_LANDED;
    endcase
  end

  fms_target_conv u_tgt (
    .alt_target_i (alt_goal_d),
    .yaw_target_i (yaw_goal_d),
    .counts_o     (counts),
    .steps_o      (steps)
  );

  // State update once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_LANDED;
      alt_goal_q   <= 7'd0;
      yaw_goal_q   <= 9'sd0;
      start_cnt_q  <= 5'd0;
      start_done_q <= 1'b0;
      gref_q       <= '0;
      main_on_q    <= 1'b0;
      tail_on_q    <= 1'b0;
    end else if (advance) begin
      mode_q       <= mode_d;
      alt_goal_q   <= alt_goal_d;
      yaw_goal_q   <= yaw_goal_d;
      start_cnt_q  <= start_cnt_d;
      start_done_q <= start_done_d;
      gref_q       <= gref_d;
      main_on_q    <= main_on_d;
      tail_on_q    <= tail_on_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q   <= mode_code;
      out_pct_q    <= s1_pct_q;
      out_alt_q    <= alt_goal_d;
      out_yaw_q    <= yaw_goal_d;
      out_counts_q <= counts;
      out_steps_q  <= steps;
      out_main_q   <= main_on_d;
      out_tail_q   <= tail_on_d;
      out_aload_q  <= aload;
      out_yload_q  <= yload;
      out_cmain_q  <= cmain;
      out_ctail_q  <= ctail;
    end
  end

  assign out_o.valid                  = out_valid_q;
  assign out_o.flight_mode            = out_mode_q;
  assign out_o.altitude_pct           = out_pct_q;
  assign out_o.altitude_target        = out_alt_q;
  assign out_o.yaw_target             = out_yaw_q;
  assign out_o.altitude_target_counts = out_counts_q;
  assign out_o.yaw_target_steps       = out_steps_q;
  assign out_o.main_motor_on          = out_main_q;
  assign out_o.tail_motor_on          = out_tail_q;
  assign out_o.altitude_target_load   = out_aload_q;
  assign out_o.yaw_target_load        = out_yload_q;
  assign out_o.clear_main_integrator  = out_cmain_q;
  assign out_o.clear_tail_integrator  = out_ctail_q;

  // Checks
  a_main_needs_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_on_q |-> tail_on_q)
    else $error("main motor enabled without tail motor");

  a_landed_motors_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_LANDED) |-> (!main_on_q && !tail_on_q))
    else $error("motor enabled while landed");

  a_airborne_main_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == MODE_HOVER) || (mode_q == MODE_FLYING)) |-> main_on_q)
    else $error("hover or flying without main motor");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      ($stable(mode_q) && $stable(alt_goal_q) && $stable(yaw_goal_q)))
    else $error("sequencer state moved while result stalled");

endmodule

`default_nettype wire

// ===== bench/fms_setpoint_monitor.sv =====
// Setpoint monitor: predicts each tick's setpoints and compares them with the result channel.
`timescale 1ns / 1ps

module fms_setpoint_monitor #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  fms_cfg_if   cfg_i,
  fms_in_if    tick_i,
  fms_out_if   result_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  typedef struct {
    fms_pkg::flight_mode_e mode;
    logic signed [9:0] altitude_pct;
    logic [6:0]        altitude_goal;
    logic signed [8:0] yaw_goal;
    logic [10:0]       goal_counts;
    logic signed [8:0] goal_steps;
    logic              main_on;
    logic              tail_on;
    logic              altitude_load;
    logic              yaw_load;
    logic              clear_main;
    logic              clear_tail;
  } setpoint_t;

  // Register copies
  int cfg_alt_tol, cfg_yaw_tol, cfg_alt_step, cfg_yaw_step;
  int cfg_start_delay, cfg_alt_ceil, cfg_hover_yaw;

  // Sequencer state
  fms_pkg::flight_mode_e mode_now;
  int           alt_goal, yaw_goal, startup_ticks, ground_ref;
  logic         startup_done, main_on, tail_on;

  setpoint_t setpoints_due[$];
  setpoint_t want;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // One control tick: altitude percent first, then the mode logic
  function automatic setpoint_t advance_sequencer(input int height, input int yaw_meas,
                                                  input logic sw, input logic up,
                                                  input logic down, input logic left,
                                                  input logic right, input logic found);
    setpoint_t r;
    int        pct, steps;
    logic      near, aload, yload, cmain, ctail;
    aload = 1'b0;
    yload = 1'b0;
    cmain = 1'b0;
    ctail = 1'b0;
    pct = (ground_ref - height) * 100 / 1241;
    if (pct > 511) pct = 511;
    if (pct < -512) pct = -512;

    case (mode_now)
      fms_pkg::FM_TAKEOFF: begin
        if (startup_done && magnitude(pct - alt_goal) <= cfg_alt_tol) begin
          mode_now = fms_pkg::FM_HOVER;
          yaw_goal = cfg_hover_yaw;
          yload    = 1'b1;
        end
        if (!startup_done) begin
          if (startup_ticks >= cfg_start_delay) begin
            cmain        = 1'b1;
            main_on      = 1'b1;
            alt_goal     = (cfg_alt_step > cfg_alt_ceil) ? cfg_alt_ceil : cfg_alt_step;
            aload        = 1'b1;
            startup_done = 1'b1;
          end else begin
            startup_ticks = (startup_ticks + 1) & 31;
          end
        end
      end
      fms_pkg::FM_HOVER: begin
        ctail = 1'b1;
        if (found) begin
          yload    = 1'b1;
          yaw_goal = 0;
          mode_now = fms_pkg::FM_FLYING;
        end
      end
      fms_pkg::FM_FLYING: begin
        // up before down, right before left
        if (up) begin
          alt_goal += cfg_alt_step;
          if (alt_goal > cfg_alt_ceil) alt_goal = cfg_alt_ceil;
          aload = 1'b1;
        end
        if (down) begin
          alt_goal -= cfg_alt_step;
          if (alt_goal < 0) alt_goal = 0;
          aload = 1'b1;
        end
        if (right) begin
          if (yaw_goal >= 180) yaw_goal = -180;
          yaw_goal += cfg_yaw_step;
          yload = 1'b1;
        end
        if (left) begin
          if (yaw_goal <= -180 + cfg_yaw_step) yaw_goal = 180 + cfg_yaw_step;
          yaw_goal -= cfg_yaw_step;
          yload = 1'b1;
        end
        if (!sw) begin
          mode_now = fms_pkg::FM_LANDING;
          yaw_goal = 0;
          yload    = 1'b1;
        end
      end
      fms_pkg::FM_LANDING: begin
        // step down when aligned and low enough, then check for touchdown
        near = magnitude(yaw_meas) <= cfg_yaw_tol && pct <= alt_goal + cfg_alt_tol;
        if (near && alt_goal > 0) begin
          alt_goal -= cfg_alt_step;
          if (alt_goal < 0) alt_goal = 0;
          aload = 1'b1;
        end
        near = magnitude(yaw_meas) <= cfg_yaw_tol && pct <= alt_goal + cfg_alt_tol;
        if (near && alt_goal == 0) begin
          mode_now = fms_pkg::FM_LANDED;
          main_on  = 1'b0;
          tail_on  = 1'b0;
        end
      end
      default: begin
        // landed: ground reference follows the sample
        mode_now   = fms_pkg::FM_LANDED;
        ground_ref = height;
        if (sw) begin
          tail_on       = 1'b1;
          yaw_goal      = 0;
          startup_ticks = 0;
          startup_done  = 1'b0;
          yload         = 1'b1;
          cmain         = 1'b1;
          mode_now      = fms_pkg::FM_TAKEOFF;
        end
      end
    endcase

    steps = yaw_goal * 112 / 90;
    if (steps > 255) steps = 255;
    if (steps < -256) steps = -256;

    r.mode          = mode_now;
    r.altitude_pct  = pct[9:0];
    r.altitude_goal = alt_goal[6:0];
    r.yaw_goal      = yaw_goal[8:0];
    r.goal_counts   = 11'(alt_goal * 1241 / 100);
    r.goal_steps    = steps[8:0];
    r.main_on       = main_on;
    r.tail_on       = tail_on;
    r.altitude_load = aload;
    r.yaw_load      = yload;
    r.clear_main    = cmain;
    r.clear_tail    = ctail;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  // Watch the three channels; ticks are predicted before results are retired
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_alt_tol      = 4;
      cfg_yaw_tol      = 5;
      cfg_alt_step     = 10;
      cfg_yaw_step     = 15;
      cfg_start_delay  = 10;
      cfg_alt_ceil     = 100;
      cfg_hover_yaw    = -30;
      mode_now         = fms_pkg::FM_LANDED;
      alt_goal         = 0;
      yaw_goal         = 0;
      startup_ticks    = 0;
      startup_done     = 1'b0;
      ground_ref       = 0;
      main_on          = 1'b0;
      tail_on          = 1'b0;
      setpoints_due.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (fms_pkg::cfg_idx_e'(cfg_i.index))
          fms_pkg::CFG_ALT_TOL:     cfg_alt_tol     = int'(cfg_i.data[4:0]);
          fms_pkg::CFG_YAW_TOL:     cfg_yaw_tol     = int'(cfg_i.data[4:0]);
          fms_pkg::CFG_ALT_STEP:    cfg_alt_step    = int'(cfg_i.data[5:0]);
          fms_pkg::CFG_YAW_STEP:    cfg_yaw_step    = int'(cfg_i.data[5:0]);
          fms_pkg::CFG_START_DELAY: cfg_start_delay = int'(cfg_i.data[4:0]);
          fms_pkg::CFG_ALT_CEIL:    cfg_alt_ceil    = int'(cfg_i.data[6:0]);
          fms_pkg::CFG_HOVER_YAW:   cfg_hover_yaw   = int'($signed(cfg_i.data));
          default: ;
        endcase
      end

      if (tick_i.valid && tick_i.ready) begin
        setpoints_due.push_back(advance_sequencer(
          int'(tick_i.height_sample), int'(tick_i.measured_yaw), tick_i.switch_up,
          tick_i.push_up, tick_i.push_down, tick_i.push_left, tick_i.push_right,
          tick_i.reference_found));
      end

      if (result_i.valid && result_i.ready) begin
        if (setpoints_due.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatch_count_o++;
        end else begin
          want = setpoints_due.pop_front();
          check_field("flight_mode", 32'(want.mode), 32'(result_i.flight_mode));
          check_field("altitude_pct", 32'(want.altitude_pct), 32'(result_i.altitude_pct));
          check_field("altitude_target", 32'(want.altitude_goal),
                      32'(result_i.altitude_target));
          check_field("yaw_target", 32'(want.yaw_goal), 32'(result_i.yaw_target));
          check_field("altitude_target_counts", 32'(want.goal_counts),
                      32'(result_i.altitude_target_counts));
          check_field("yaw_target_steps", 32'(want.goal_steps),
                      32'(result_i.yaw_target_steps));
          check_field("main_motor_on", 32'(want.main_on), 32'(result_i.main_motor_on));
          check_field("tail_motor_on", 32'(want.tail_on), 32'(result_i.tail_motor_on));
          check_field("altitude_target_load", 32'(want.altitude_load),
                      32'(result_i.altitude_target_load));
          check_field("yaw_target_load", 32'(want.yaw_load),
                      32'(result_i.yaw_target_load));
          check_field("clear_main_integrator", 32'(want.clear_main),
                      32'(result_i.clear_main_integrator));
          check_field("clear_tail_integrator", 32'(want.clear_tail),
                      32'(result_i.clear_tail_integrator));
        end
      end
      pending_o = setpoints_due.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: clock, reset, register settings, tick stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    logic [SAMPLE_BITS-1:0] height;
    logic signed [8:0]      yaw;
    logic                   sw;
    logic                   up;
    logic                   down;
    logic                   left;
    logic                   right;
    logic                   found;
  } tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_sent    = 0;
  int mismatches, outstanding;

  // Register values currently loaded, used to shape flights
  int set_alt_tol, set_yaw_tol, set_alt_step, set_yaw_step;
  int set_start_delay, set_alt_ceil, set_hover_yaw;

  fms_cfg_if                                   cfg_if ();
  fms_in_if #(.SAMPLE_BITS(SAMPLE_BITS))       tick_if ();
  fms_out_if                                   result_if ();

  flight_mode_setpoint_sequencer #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (tick_if),
    .out_o  (result_if)
  );

  fms_setpoint_monitor #(.SAMPLE_BITS(SAMPLE_BITS)) u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_if),
    .tick_i           (tick_if),
    .result_i         (result_if),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #400000;
    $display("flight_mode_setpoint_sequencer verification failed");
    $finish;
  end

  // Result backpressure
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tick_t mk(input int height, input int yaw, input int sw,
                               input int up, input int down, input int left,
                               input int right, input int found);
    tick_t t;
    t.height = height[SAMPLE_BITS-1:0];
    t.yaw    = yaw[8:0];
    t.sw     = sw[0];
    t.up     = up[0];
    t.down   = down[0];
    t.left   = left[0];
    t.right  = right[0];
    t.found  = found[0];
    return t;
  endfunction

  function automatic tick_t random_tick();
    return mk($urandom_range(SAMPLE_MAX), int'($urandom_range(360)) - 180,
              $urandom_range(1), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1), $urandom_range(1));
  endfunction

  function automatic int spread(input int w);
    return int'($urandom_range(2 * w)) - w;
  endfunction

  // Sample that reads as the given altitude percent over the ground value
  function automatic int height_at(input int ground, input int pct);
    int h;
    if (pct >= 0) h = ground - (pct * 1241 + 99) / 100;
    else h = ground - pct * 13;
    if (h < 0) h = 0;
    if (h > SAMPLE_MAX) h = SAMPLE_MAX;
    return h;
  endfunction

  task automatic write_register(input fms_pkg::cfg_idx_e idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= fms_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input int alt_tol, input int yaw_tol, input int alt_step,
                               input int yaw_step, input int delay, input int ceiling,
                               input int hover_yaw);
    write_register(fms_pkg::CFG_ALT_TOL, alt_tol);
    write_register(fms_pkg::CFG_YAW_TOL, yaw_tol);
    write_register(fms_pkg::CFG_ALT_STEP, alt_step);
    write_register(fms_pkg::CFG_YAW_STEP, yaw_step);
    write_register(fms_pkg::CFG_START_DELAY, delay);
    write_register(fms_pkg::CFG_ALT_CEIL, ceiling);
    write_register(fms_pkg::CFG_HOVER_YAW, hover_yaw);
    cfg_if.valid    <= 1'b0;
    set_alt_tol     = alt_tol;
    set_yaw_tol     = yaw_tol;
    set_alt_step    = alt_step;
    set_yaw_step    = yaw_step;
    set_start_delay = delay;
    set_alt_ceil    = ceiling;
    set_hover_yaw   = hover_yaw;
  endtask

  // One tick transaction with random sender gaps ahead of it
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid           <= 1'b1;
    tick_if.height_sample   <= t.height;
    tick_if.measured_yaw    <= t.yaw;
    tick_if.switch_up       <= t.sw;
    tick_if.push_up         <= t.up;
    tick_if.push_down       <= t.down;
    tick_if.push_left       <= t.left;
    tick_if.push_right      <= t.right;
    tick_if.reference_found <= t.found;
    do @(posedge clk_i); while (!tick_if.ready);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // Hold the sender until every outstanding result has been retired
  task automatic drain();
    tick_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // A complete flight: sit, spin up, climb, hover, fly, land
  task automatic fly_once();
    int    ground, climb_goal, n;
    tick_t t;
    ground     = $urandom_range(SAMPLE_MAX, 1400);
    climb_goal = (set_alt_step > set_alt_ceil) ? set_alt_ceil : set_alt_step;

    n = $urandom_range(3, 1);
    repeat (n) begin
      t        = random_tick();
      t.sw     = 1'b0;
      t.height = SAMPLE_BITS'(height_at(ground, spread(2)));
      send_tick(t);
    end

    // switch up captures the ground reference
    t        = random_tick();
    t.sw     = 1'b1;
    t.height = SAMPLE_BITS'(ground);
    send_tick(t);

    repeat (set_start_delay + 1) begin
      t        = random_tick();
      t.sw     = 1'b1;
      t.found  = 1'b0;
      t.height = SAMPLE_BITS'(height_at(ground, spread(1)));
      send_tick(t);
    end

    // climb; mostly inside the tolerance, last tick right on target
    n = $urandom_range(5, 1);
    for (int i = 0; i < n; i++) begin
      t        = random_tick();
      t.sw     = 1'b1;
      t.found  = 1'b0;
      t.height = SAMPLE_BITS'(height_at(ground, climb_goal +
                 ((i == n - 1) ? 0 : spread(set_alt_tol + 3))));
      send_tick(t);
    end

    n = $urandom_range(3, 0);
    repeat (n + 1) begin
      t        = random_tick();
      t.sw     = 1'b1;
      t.found  = (n == 0);
      t.height = SAMPLE_BITS'(height_at(ground, climb_goal));
      send_tick(t);
      n--;
    end

    n = $urandom_range(40, 5);
    repeat (n) begin
      t        = random_tick();
      t.sw     = ($urandom_range(99) >= 3);
      t.up     = ($urandom_range(99) < 25);
      t.down   = ($urandom_range(99) < 25);
      t.left   = ($urandom_range(99) < 25);
      t.right  = ($urandom_range(99) < 25);
      t.height = SAMPLE_BITS'(height_at(ground, int'($urandom_range(110)) - 5));
      send_tick(t);
    end

    // landing: mostly aligned and at or below the current step
    n = (set_alt_ceil + set_alt_step - 1) / set_alt_step + $urandom_range(8, 2);
    repeat (n) begin
      t    = random_tick();
      t.sw = 1'b0;
      if ($urandom_range(99) < 85) begin
        t.yaw    = 9'(spread(set_yaw_tol));
        t.height = SAMPLE_BITS'(height_at(ground, -int'($urandom_range(3))));
      end
      send_tick(t);
    end
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(20, 5);
    repeat (n) send_tick(random_tick());
  endtask

  initial begin
    int target;
    logic paused;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = fms_pkg::CFG_ALT_TOL;
    cfg_if.data             = '0;
    tick_if.valid           = 1'b0;
    tick_if.height_sample   = '0;
    tick_if.measured_yaw    = '0;
    tick_if.switch_up       = 1'b0;
    tick_if.push_up         = 1'b0;
    tick_if.push_down       = 1'b0;
    tick_if.push_left       = 1'b0;
    tick_if.push_right      = 1'b0;
    tick_if.reference_found = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed flight with wide tolerances and no startup delay
    send_idle_pct = 27;
    recv_idle_pct = 48;
    load_settings(31, 31, 50, 45, 0, 100, -180);
    send_tick(mk(SAMPLE_MAX, 0, 0, 0, 0, 0, 0, 0));    // landed, ref to full scale
    send_tick(mk(0, -180, 0, 0, 0, 0, 0, 1));          // largest positive percent
    send_tick(mk(SAMPLE_MAX, 180, 1, 1, 1, 1, 1, 1));  // most negative, take-off
    send_tick(mk(SAMPLE_MAX, 0, 1, 0, 0, 0, 0, 0));    // main start, target set to step
    send_tick(mk(3475, 0, 1, 0, 0, 0, 0, 0));          // reach hover
    send_tick(mk(3475, 0, 1, 0, 0, 0, 0, 0));          // hover, seeking reference
    send_tick(mk(3475, 0, 1, 0, 0, 0, 0, 1));          // reference found
    send_tick(mk(3475, 0, 1, 1, 1, 1, 1, 0));          // all four buttons at once
    send_tick(mk(3475, 0, 1, 1, 0, 0, 0, 0));
    send_tick(mk(3475, 0, 1, 1, 0, 0, 0, 0));          // ceiling clamp
    repeat (5) send_tick(mk(3475, 0, 1, 0, 0, 0, 1, 0)); // right, wraps past 180
    send_tick(mk(3475, 0, 1, 0, 0, 1, 0, 0));          // left wrap
    send_tick(mk(3475, 0, 1, 0, 1, 0, 0, 0));
    send_tick(mk(3475, 0, 1, 0, 1, 0, 0, 0));
    send_tick(mk(3475, 0, 1, 0, 1, 0, 0, 0));          // floor saturation
    send_tick(mk(3475, 0, 1, 1, 0, 0, 0, 0));
    send_tick(mk(3475, 0, 0, 0, 0, 0, 0, 0));          // switch down, landing
    send_tick(mk(SAMPLE_MAX, 180, 0, 0, 0, 0, 0, 0));  // yaw off, no step
    send_tick(mk(SAMPLE_MAX, -31, 0, 0, 0, 0, 0, 0));  // step to zero and touch down
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0));

    // Random flights under several register settings
    for (int blk = 0; blk < 6; blk++) begin
      drain();
      case (blk / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (blk)
        0: load_settings(0, 0, 1, 1, 0, 0, -180);
        1: load_settings(31, 31, 50, 45, 31, 100, 180);
        2: load_settings(4, 5, 10, 15, 10, 100, -30);
        default: load_settings($urandom_range(31), $urandom_range(31),
                               $urandom_range(50, 1), $urandom_range(45, 1),
                               $urandom_range(31), $urandom_range(100),
                               int'($urandom_range(360)) - 180);
      endcase
      target = ticks_sent + 275;
      paused = 1'b0;
      while (ticks_sent < target) begin
        if (!paused && ticks_sent >= target - 150) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 12) noise_burst();
        else fly_once();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("flight_mode_setpoint_sequencer verification clean");
    end else begin
      $display("flight_mode_setpoint_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== flight_mode_setpoint_sequencer.f =====
hw/rtl/fms_pkg.sv
hw/rtl/fms_if.sv
hw/rtl/fms_pct_conv.sv
hw/rtl/fms_target_conv.sv
hw/rtl/flight_mode_setpoint_sequencer.sv
bench/fms_setpoint_monitor.sv
bench/testbench.sv
